>>> sv/alsf_pkg.sv
package alsf_pkg;

    localparam int BLK_W  = 20;
    localparam int TAG_W  = 21;
    localparam int DATA_W = 32;
    localparam int SEL_W  = 2;
    localparam int TIME_W = 32;

    localparam logic [TAG_W-1:0] TAG_NONE = {TAG_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_LOOKUP    = 3'd0,
        CMD_VICTIM    = 3'd1,
        CMD_FILL      = 3'd2,
        CMD_INSTALL   = 3'd3,
        CMD_WRITE     = 3'd4,
        CMD_READ      = 3'd5,
        CMD_SET_STATE = 3'd6,
        CMD_SET_TIME  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        LS_INVALID   = 2'd0,
        LS_EXCLUSIVE = 2'd1,
        LS_MODIFIED  = 2'd2,
        LS_SHARED    = 2'd3
    } t_lstate;

endpackage

>>> sv/alsf_pick.sv
module alsf_pick #(
    parameter int STAMP_BITS = 32,
    parameter int IDX_W      = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr,
    input  logic                         i_en,
    input  logic                         i_lookup,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic [alsf_pkg::TAG_W-1:0]   i_key,
    input  logic [alsf_pkg::TAG_W-1:0]   i_tag,
    input  logic [1:0]                   i_state,
    input  logic [STAMP_BITS-1:0]        i_stamp,
    output logic                         o_hit,
    output logic [IDX_W-1:0]             o_line
);
    import alsf_pkg::*;

    logic                  r_hit,  n_hit;
    logic [IDX_W-1:0]      r_line, n_line;
    logic [STAMP_BITS-1:0] r_best, n_best;

    always_comb begin
        n_hit  = r_hit;
        n_line = r_line;
        n_best = r_best;
        if (i_clr) begin
            n_hit  = 1'b0;
            n_line = '0;
            n_best = '0;
        end else if (i_en) begin
            if (i_lookup) begin
                if (!r_hit && i_tag == i_key && i_state != LS_INVALID) begin
                    n_hit  = 1'b1;
                    n_line = i_idx;
                end
            end else begin
                if (i_idx == '0 || i_stamp < r_best) begin
                    n_best = i_stamp;
                    n_line = i_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_line <= '0;
        end else begin
            r_hit  <= n_hit;
            r_line <= n_line;
        end
        r_best <= n_best;
    end

    assign o_hit  = r_hit;
    assign o_line = r_line;

endmodule

>>> sv/assoc_line_store_fifo_victim.sv
// Lookup and victim: one shared tag/stamp compare unit steps through the line memory,
// then the word is read and the command executed; one command is in flight at a time.
// Other commands: a read state, then an execute state (read, then write).
// Synchronous active-low reset, then a clearing pass through the word and line memories
// before the first command is accepted.
module assoc_line_store_fifo_victim #(
    parameter int NUM_LINES      = 4,
    parameter int WORDS_PER_LINE = 4,
    parameter int STAMP_BITS     = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_cmd,
    input  logic [alsf_pkg::BLK_W-1:0]         i_block_tag,
    input  logic [alsf_pkg::SEL_W-1:0]         i_line_sel,
    input  logic [alsf_pkg::SEL_W-1:0]         i_word_sel,
    input  logic signed [alsf_pkg::DATA_W-1:0] i_word_value,
    input  logic [1:0]                         i_state_in,
    input  logic [alsf_pkg::TIME_W-1:0]        i_time_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic [alsf_pkg::SEL_W-1:0]         o_line_out,
    output logic signed [alsf_pkg::DATA_W-1:0] o_word_out,
    output logic [1:0]                         o_state_out,
    output logic signed [alsf_pkg::TAG_W-1:0]  o_tag_out,
    output logic [alsf_pkg::TIME_W-1:0]        o_time_out
);
    import alsf_pkg::*;

    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int IDX_W  = $clog2(NUM_LINES + 1);
    localparam int WORD_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int DEPTH  = NUM_LINES * WORDS_PER_LINE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLR_W  = $clog2(DEPTH + 1);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_READ, S_EXEC} t_state;

    logic [TAG_W-1:0]      m_tag   [NUM_LINES];
    logic [1:0]            m_st    [NUM_LINES];
    logic [STAMP_BITS-1:0] m_stamp [NUM_LINES];
    logic [DATA_W-1:0]     m_word  [DEPTH];

    t_state                r_state;
    logic [CLR_W-1:0]      r_clr;
    logic [IDX_W-1:0]      r_idx;
    logic [STAMP_BITS-1:0] r_count;

    t_cmd                  r_cmd;
    logic [BLK_W-1:0]      r_blk;
    logic                  r_line_ok;
    logic                  r_word_ok;
    logic [LINE_W-1:0]     r_line_idx;
    logic [ADDR_W-1:0]     r_waddr;
    logic [DATA_W-1:0]     r_value;
    logic [1:0]            r_st_in;
    logic [STAMP_BITS-1:0] r_time;

    logic [TAG_W-1:0]      r_tag_q;
    logic [1:0]            r_st_q;
    logic [STAMP_BITS-1:0] r_stamp_q;
    logic [DATA_W-1:0]     r_word_q;

    logic                  r_out_valid;
    logic                  r_hit;
    logic [SEL_W-1:0]      r_line_out;
    logic [DATA_W-1:0]     r_word_out;
    logic [1:0]            r_state_out;
    logic [TAG_W-1:0]      r_tag_out;
    logic [TIME_W-1:0]     r_time_out;

    logic                  in_go;
    logic                  exec_go;
    logic                  in_scan;
    logic [LINE_W-1:0]     in_line_idx;
    logic [WORD_W-1:0]     in_word_idx;
    logic [LINE_W-1:0]     rd_line;
    logic                  meta_we;
    logic                  word_we;
    logic [LINE_W-1:0]     wr_line;
    logic [ADDR_W-1:0]     wr_addr;
    logic [TAG_W-1:0]      n_tag;
    logic [1:0]            n_st;
    logic [STAMP_BITS-1:0] n_stamp;
    logic [DATA_W-1:0]     n_word;
    logic                  cnt_inc;
    logic                  pick_hit;
    logic [IDX_W-1:0]      pick_line;
    logic [IDX_W-1:0]      cmp_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_go       = i_in_valid && o_in_ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign in_scan     = (t_cmd'(i_cmd) == CMD_LOOKUP) || (t_cmd'(i_cmd) == CMD_VICTIM);
    assign in_line_idx = LINE_W'(i_line_sel);
    assign in_word_idx = WORD_W'(i_word_sel);
    assign cmp_idx     = IDX_W'(r_idx - 1'b1);

    always_comb begin
        rd_line = r_line_idx;
        if (r_state == S_SCAN && int'(r_idx) < NUM_LINES) begin
            rd_line = LINE_W'(r_idx);
        end
    end

    alsf_pick #(
        .STAMP_BITS (STAMP_BITS),
        .IDX_W      (IDX_W)
    ) u_pick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (in_go),
        .i_en     (r_state == S_SCAN && r_idx != '0),
        .i_lookup (r_cmd == CMD_LOOKUP),
        .i_idx    (cmp_idx),
        .i_key    ({1'b0, r_blk}),
        .i_tag    (r_tag_q),
        .i_state  (r_st_q),
        .i_stamp  (r_stamp_q),
        .o_hit    (pick_hit),
        .o_line   (pick_line)
    );

    always_comb begin
        n_tag   = r_tag_q;
        n_st    = r_st_q;
        n_stamp = r_stamp_q;
        n_word  = r_word_q;
        meta_we = 1'b0;
        word_we = 1'b0;
        cnt_inc = 1'b0;
        wr_line = r_line_idx;
        wr_addr = r_waddr;
        if (r_state == S_CLEAR) begin
            n_tag   = TAG_NONE;
            n_st    = LS_INVALID;
            n_stamp = '0;
            n_word  = '0;
            wr_line = LINE_W'(r_clr);
            wr_addr = ADDR_W'(r_clr);
            meta_we = int'(r_clr) < NUM_LINES;
            word_we = 1'b1;
        end else if (exec_go) begin
            case (r_cmd)
                CMD_FILL: begin
                    if (r_line_ok && r_word_ok) begin
                        n_word  = r_value;
                        word_we = 1'b1;
                    end
                end
                CMD_INSTALL: begin
                    if (r_line_ok) begin
                        n_tag   = {1'b0, r_blk};
                        n_st    = r_st_in;
                        n_stamp = r_count;
                        meta_we = 1'b1;
                        cnt_inc = (r_count != STAMP_MAX);
                    end
                end
                CMD_WRITE: begin
                    if (r_line_ok && r_word_ok) begin
                        n_word  = r_value;
                        n_st    = LS_MODIFIED;
                        word_we = 1'b1;
                        meta_we = 1'b1;
                    end
                end
                CMD_SET_STATE: begin
                    if (r_line_ok) begin
                        n_st    = r_st_in;
                        meta_we = 1'b1;
                    end
                end
                CMD_SET_TIME: begin
                    if (r_line_ok) begin
                        n_stamp = r_time;
                        meta_we = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            m_tag[wr_line]   <= n_tag;
            m_st[wr_line]    <= n_st;
            m_stamp[wr_line] <= n_stamp;
        end
        if (word_we) begin
            m_word[wr_addr] <= n_word;
        end
        r_tag_q   <= m_tag[rd_line];
        r_st_q    <= m_st[rd_line];
        r_stamp_q <= m_stamp[rd_line];
        r_word_q  <= m_word[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_count     <= STAMP_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !exec_go) begin
                r_out_valid <= 1'b0;
            end
            if (cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= CLR_W'(r_clr + 1'b1);
                    if (int'(r_clr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_go) begin
                        r_idx   <= '0;
                        r_state <= in_scan ? S_SCAN : S_READ;
                    end
                end
                S_SCAN: begin
                    if (int'(r_idx) == NUM_LINES) begin
                        r_state <= S_READ;
                    end else begin
                        r_idx <= IDX_W'(r_idx + 1'b1);
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        r_hit       <= (r_cmd == CMD_LOOKUP) && pick_hit;
                        r_line_out  <= ((r_cmd == CMD_LOOKUP && pick_hit) ||
                                        r_cmd == CMD_VICTIM) ? SEL_W'(pick_line) : '0;
                        if (r_line_ok) begin
                            r_word_out  <= r_word_ok ? n_word : '0;
                            r_state_out <= n_st;
                            r_tag_out   <= n_tag;
                            r_time_out  <= TIME_W'(n_stamp);
                        end else begin
                            r_word_out  <= '0;
                            r_state_out <= LS_INVALID;
                            r_tag_out   <= TAG_NONE;
                            r_time_out  <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_blk      <= i_block_tag;
            r_line_ok  <= int'(i_line_sel) < NUM_LINES;
            r_word_ok  <= int'(i_word_sel) < WORDS_PER_LINE;
            r_line_idx <= in_line_idx;
            r_waddr    <= ADDR_W'(int'(in_line_idx) * WORDS_PER_LINE + int'(in_word_idx));
            r_value    <= i_word_value;
            r_st_in    <= i_state_in;
            r_time     <= STAMP_BITS'(i_time_in);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_line_out  = r_line_out;
    assign o_word_out  = signed'(r_word_out);
    assign o_state_out = r_state_out;
    assign o_tag_out   = signed'(r_tag_out);
    assign o_time_out  = r_time_out;

endmodule
